>>> rtl/core/cqf_pkg.sv
// Shared types, constants and helpers for the Cholesky quadratic form unit.
// Used by all other RTL files; no dependencies.
package cqf_pkg;

  localparam int VAL_W  = 32;
  localparam int ACC_W  = 64;
  localparam int FRAC_W = 16;
  localparam int DIM_W  = 5;

  typedef enum logic [3:0] {
    OP_NOP, OP_INIT, OP_CLR, OP_LDA, OP_LDB, OP_MUL, OP_SUB, OP_ADD,
    OP_SQRT, OP_DIV, OP_WR_L, OP_WR_P, OP_WR_S
  } op_t;

  typedef enum logic [2:0] {SRC_M, SRC_L, SRC_V, SRC_S, SRC_P} src_t;

  typedef enum logic [1:0] {PH_CHOL, PH_FWD, PH_BWD, PH_DOT} phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT_RD, ST_INIT, ST_RD1, ST_LD1, ST_LD2, ST_MUL, ST_ACC,
    ST_END, ST_DLD, ST_GO, ST_WAIT, ST_WR, ST_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    src_t src;
    logic load_out;
    logic fail;
  } ctrl_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic acc_nonpos;
  } dp_status_t;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] sum;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

>>> rtl/core/cqf_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Uses cqf_pkg widths; result saturates to the signed 32-bit maximum.
module cqf_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cqf_pkg::ACC_W-1:0] radicand,
  output logic                      done,
  output logic [cqf_pkg::VAL_W-1:0] root_out
);

  logic                      busy;
  logic [4:0]                cnt;
  logic [cqf_pkg::ACC_W-1:0] rad;
  logic [34:0]               rem;
  logic [31:0]               root;
  logic [34:0]               rem_sh;
  logic [34:0]               trial;
  logic                      ge;

  assign rem_sh = {rem[32:0], rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[61:0], 2'b00};
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[30:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root_out = root[31] ? 32'h7FFF_FFFF : root;

endmodule

>>> rtl/core/cqf_div.sv
// Bit-serial signed divider, 64-bit dividend by positive 32-bit divisor.
// Truncates toward zero and saturates to signed 32 bits; uses cqf_pkg widths.
module cqf_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [cqf_pkg::ACC_W-1:0] num,
  input  logic signed [cqf_pkg::VAL_W-1:0] den,
  output logic                             done,
  output logic signed [cqf_pkg::VAL_W-1:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] q;
  logic [31:0] rem;
  logic [31:0] dv;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, q[63]};
  assign ge     = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[63];
        q    <= num[63] ? 64'(-num) : 64'(num);
        rem  <= '0;
        dv   <= 32'(den);
      end else if (busy) begin
        rem <= ge ? 32'(rem_sh - {1'b0, dv}) : rem_sh[31:0];
        q   <= {q[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      quot = (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    end else begin
      quot = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    end
  end

endmodule

>>> rtl/core/cqf_datapath.sv
// Datapath: matrix, factor, vector, solution and pivot memories, the
// multiply-accumulate path, and the divider and square root units.
// Depends on cqf_pkg, cqf_div and cqf_sqrt.
module cqf_datapath #(
  parameter int MAX_DIM = 16,
  parameter int IW      = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_we,
  input  logic                             in_cmd,
  input  logic [3:0]                       in_row,
  input  logic [3:0]                       in_col,
  input  logic signed [cqf_pkg::VAL_W-1:0] in_value,
  input  cqf_pkg::ctrl_cmd_t               cmd,
  input  logic [IW-1:0]                    ar,
  input  logic [IW-1:0]                    ac,
  output cqf_pkg::dp_status_t              status,
  output logic signed [cqf_pkg::ACC_W-1:0] acc
);

  localparam int D1 = 1 << IW;
  localparam int D2 = 1 << (2 * IW);

  logic signed [cqf_pkg::VAL_W-1:0] mem_m [D2];
  logic signed [cqf_pkg::VAL_W-1:0] mem_l [D2];
  logic signed [cqf_pkg::VAL_W-1:0] mem_v [D1];
  logic signed [cqf_pkg::VAL_W-1:0] mem_s [D1];
  logic signed [cqf_pkg::VAL_W-1:0] mem_p [D1];

  logic signed [cqf_pkg::VAL_W-1:0] rd_m, rd_l, rd_v, rd_s, rd_p, rd_sel;
  logic signed [cqf_pkg::VAL_W-1:0] opa, opb, res;
  logic signed [cqf_pkg::ACC_W-1:0] prod;
  logic [IW-1:0]                    in_r, in_c;
  logic                             m_we, v_we;
  logic                             sqrt_done, div_done;
  logic [cqf_pkg::VAL_W-1:0]        sqrt_root;
  logic signed [cqf_pkg::VAL_W-1:0] div_quot;

  assign in_r = IW'(in_row);
  assign in_c = IW'(in_col);
  assign m_we = in_we && !in_cmd && (in_row <= in_col)
                && (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign v_we = in_we && in_cmd && (int'(in_row) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (m_we) begin
      mem_m[{in_r, in_c}] <= in_value;
    end
    if (v_we) begin
      mem_v[in_r] <= in_value;
    end
    if (cmd.op == cqf_pkg::OP_WR_L || cmd.op == cqf_pkg::OP_WR_P) begin
      mem_l[{ar, ac}] <= res;
    end
    if (cmd.op == cqf_pkg::OP_WR_P) begin
      mem_p[ar] <= res;
    end
    if (cmd.op == cqf_pkg::OP_WR_S) begin
      mem_s[ar] <= res;
    end
    rd_m <= mem_m[{ar, ac}];
    rd_l <= mem_l[{ar, ac}];
    rd_v <= mem_v[ar];
    rd_s <= mem_s[ar];
    rd_p <= mem_p[ar];
  end

  always_comb begin
    unique case (cmd.src)
      cqf_pkg::SRC_M: rd_sel = rd_m;
      cqf_pkg::SRC_L: rd_sel = rd_l;
      cqf_pkg::SRC_V: rd_sel = rd_v;
      cqf_pkg::SRC_S: rd_sel = rd_s;
      cqf_pkg::SRC_P: rd_sel = rd_p;
      default:        rd_sel = rd_m;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cqf_pkg::OP_INIT: acc  <= {{(cqf_pkg::FRAC_W){rd_sel[31]}}, rd_sel,
                                 {(cqf_pkg::FRAC_W){1'b0}}};
      cqf_pkg::OP_CLR:  acc  <= '0;
      cqf_pkg::OP_LDA:  opa  <= rd_sel;
      cqf_pkg::OP_LDB:  opb  <= rd_sel;
      cqf_pkg::OP_MUL:  prod <= opa * opb;
      cqf_pkg::OP_SUB:  acc  <= cqf_pkg::sat_add(acc, -prod);
      cqf_pkg::OP_ADD:  acc  <= cqf_pkg::sat_add(acc, prod);
      default: ;
    endcase
    if (sqrt_done) begin
      res <= sqrt_root;
    end else if (div_done) begin
      res <= div_quot;
    end
  end

  cqf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == cqf_pkg::OP_SQRT),
    .radicand (acc),
    .done     (sqrt_done),
    .root_out (sqrt_root)
  );

  cqf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == cqf_pkg::OP_DIV),
    .num   (acc),
    .den   (opb),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign status.unit_done  = sqrt_done || div_done;
  assign status.acc_nonpos = (acc <= 0);

endmodule

>>> rtl/core/cqf_ctrl.sv
// Controller: sequences factorization, forward and back substitution and
// the dot product by issuing commands to the datapath. Depends on cqf_pkg.
module cqf_ctrl #(
  parameter int MAX_DIM = 16,
  parameter int IW      = 4,
  parameter int CW      = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [cqf_pkg::DIM_W-1:0] dim,
  input  cqf_pkg::dp_status_t       status,
  input  logic                      out_free,
  output logic                      idle,
  output cqf_pkg::ctrl_cmd_t        cmd,
  output logic [IW-1:0]             ar,
  output logic [IW-1:0]             ac
);

  cqf_pkg::state_t state, state_next;
  cqf_pkg::phase_t phase, phase_next;
  logic [CW-1:0]   i, i_next, j, j_next, k, k_next;
  logic            fail, fail_next;
  logic [CW-1:0]   n;
  logic [CW-1:0]   k_inc;
  logic            more_cur, more_inc;

  always_comb begin
    if (dim == '0) begin
      n = CW'(1);
    end else if (int'(dim) > MAX_DIM) begin
      n = CW'(MAX_DIM);
    end else begin
      n = CW'(dim);
    end
  end

  assign k_inc = k + CW'(1);
  assign more_cur = (phase == cqf_pkg::PH_CHOL || phase == cqf_pkg::PH_FWD) ? (k < i) : (k < n);
  assign more_inc = (phase == cqf_pkg::PH_CHOL || phase == cqf_pkg::PH_FWD) ? (k_inc < i)
                                                                           : (k_inc < n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cqf_pkg::ST_IDLE;
      phase <= cqf_pkg::PH_CHOL;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      fail  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      fail  <= fail_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    fail_next  = fail;
    unique case (state)
      cqf_pkg::ST_IDLE: begin
        if (go) begin
          state_next = cqf_pkg::ST_INIT_RD;
          phase_next = cqf_pkg::PH_CHOL;
          i_next     = '0;
          j_next     = '0;
          fail_next  = 1'b0;
        end
      end
      cqf_pkg::ST_INIT_RD: begin
        state_next = cqf_pkg::ST_INIT;
        k_next     = (phase == cqf_pkg::PH_BWD) ? i + CW'(1) : '0;
      end
      cqf_pkg::ST_INIT: state_next = more_cur ? cqf_pkg::ST_RD1 : cqf_pkg::ST_END;
      cqf_pkg::ST_RD1:  state_next = cqf_pkg::ST_LD1;
      cqf_pkg::ST_LD1:  state_next = cqf_pkg::ST_LD2;
      cqf_pkg::ST_LD2:  state_next = cqf_pkg::ST_MUL;
      cqf_pkg::ST_MUL:  state_next = cqf_pkg::ST_ACC;
      cqf_pkg::ST_ACC: begin
        k_next     = k_inc;
        state_next = more_inc ? cqf_pkg::ST_RD1 : cqf_pkg::ST_END;
      end
      cqf_pkg::ST_END: begin
        if (phase == cqf_pkg::PH_DOT) begin
          state_next = cqf_pkg::ST_OUT;
        end else if (phase == cqf_pkg::PH_CHOL && i == j) begin
          if (status.acc_nonpos) begin
            fail_next  = 1'b1;
            state_next = cqf_pkg::ST_OUT;
          end else begin
            state_next = cqf_pkg::ST_GO;
          end
        end else begin
          state_next = cqf_pkg::ST_DLD;
        end
      end
      cqf_pkg::ST_DLD:  state_next = cqf_pkg::ST_GO;
      cqf_pkg::ST_GO:   state_next = cqf_pkg::ST_WAIT;
      cqf_pkg::ST_WAIT: begin
        if (status.unit_done) begin
          state_next = cqf_pkg::ST_WR;
        end
      end
      cqf_pkg::ST_WR: begin
        state_next = cqf_pkg::ST_INIT_RD;
        unique case (phase)
          cqf_pkg::PH_CHOL: begin
            if (j + CW'(1) == n) begin
              if (i + CW'(1) == n) begin
                phase_next = cqf_pkg::PH_FWD;
                i_next     = '0;
              end else begin
                i_next = i + CW'(1);
                j_next = i + CW'(1);
              end
            end else begin
              j_next = j + CW'(1);
            end
          end
          cqf_pkg::PH_FWD: begin
            if (i + CW'(1) == n) begin
              phase_next = cqf_pkg::PH_BWD;
              i_next     = n - CW'(1);
            end else begin
              i_next = i + CW'(1);
            end
          end
          default: begin
            if (i == '0) begin
              phase_next = cqf_pkg::PH_DOT;
            end else begin
              i_next = i - CW'(1);
            end
          end
        endcase
      end
      cqf_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = cqf_pkg::ST_IDLE;
        end
      end
      default: state_next = cqf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = cqf_pkg::OP_NOP;
    cmd.src      = cqf_pkg::SRC_M;
    cmd.load_out = 1'b0;
    cmd.fail     = fail;
    ar           = IW'(i);
    ac           = IW'(j);
    idle         = (state == cqf_pkg::ST_IDLE);
    unique case (state)
      cqf_pkg::ST_INIT: begin
        unique case (phase)
          cqf_pkg::PH_CHOL: begin
            cmd.op  = cqf_pkg::OP_INIT;
            cmd.src = cqf_pkg::SRC_M;
          end
          cqf_pkg::PH_FWD: begin
            cmd.op  = cqf_pkg::OP_INIT;
            cmd.src = cqf_pkg::SRC_V;
          end
          cqf_pkg::PH_BWD: begin
            cmd.op  = cqf_pkg::OP_INIT;
            cmd.src = cqf_pkg::SRC_S;
          end
          default: cmd.op = cqf_pkg::OP_CLR;
        endcase
      end
      cqf_pkg::ST_RD1: begin
        unique case (phase)
          cqf_pkg::PH_BWD: begin
            ar = IW'(k);
            ac = IW'(i);
          end
          cqf_pkg::PH_DOT: ar = IW'(k);
          default:         ac = IW'(k);
        endcase
      end
      cqf_pkg::ST_LD1: begin
        cmd.op  = cqf_pkg::OP_LDA;
        cmd.src = (phase == cqf_pkg::PH_DOT) ? cqf_pkg::SRC_V : cqf_pkg::SRC_L;
        if (phase == cqf_pkg::PH_CHOL) begin
          ar = IW'(j);
          ac = IW'(k);
        end else begin
          ar = IW'(k);
        end
      end
      cqf_pkg::ST_LD2: begin
        cmd.op  = cqf_pkg::OP_LDB;
        cmd.src = (phase == cqf_pkg::PH_CHOL) ? cqf_pkg::SRC_L : cqf_pkg::SRC_S;
      end
      cqf_pkg::ST_MUL: cmd.op = cqf_pkg::OP_MUL;
      cqf_pkg::ST_ACC: cmd.op = (phase == cqf_pkg::PH_DOT) ? cqf_pkg::OP_ADD : cqf_pkg::OP_SUB;
      cqf_pkg::ST_DLD: begin
        cmd.op  = cqf_pkg::OP_LDB;
        cmd.src = cqf_pkg::SRC_P;
      end
      cqf_pkg::ST_GO: begin
        cmd.op = (phase == cqf_pkg::PH_CHOL && i == j) ? cqf_pkg::OP_SQRT : cqf_pkg::OP_DIV;
      end
      cqf_pkg::ST_WR: begin
        if (phase == cqf_pkg::PH_CHOL) begin
          cmd.op = (i == j) ? cqf_pkg::OP_WR_P : cqf_pkg::OP_WR_L;
          ar     = IW'(j);
          ac     = IW'(i);
        end else begin
          cmd.op = cqf_pkg::OP_WR_S;
        end
      end
      cqf_pkg::ST_OUT: cmd.load_out = out_free;
      default: ;
    endcase
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != cqf_pkg::ST_IDLE && state != cqf_pkg::ST_OUT) |-> (i < n))
    else $error("Row counter left the dimension in use.");

  a_col_in_triangle: assert property (@(posedge clk) disable iff (rst)
    (phase == cqf_pkg::PH_CHOL && state == cqf_pkg::ST_WR) |-> (j >= i && j < n))
    else $error("Factor write outside the lower triangle.");

  a_inner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == cqf_pkg::ST_ACC) |-> (k < n))
    else $error("Inner index out of range during accumulation.");

  a_write_after_unit: assert property (@(posedge clk) disable iff (rst)
    (state == cqf_pkg::ST_WR) |-> ($past(state) == cqf_pkg::ST_WAIT))
    else $error("Result written without a finished divide or root.");

endmodule

>>> rtl/core/cholesky_quadratic_form_unit.sv
// Top level of the Cholesky quadratic form unit: stream ports, dimension
// register and result register. Depends on cqf_pkg, cqf_ctrl, cqf_datapath.
//
// Load matrix entries (upper triangle and diagonal) and vector entries at
// one transaction per cycle; the transaction with tlast set starts the
// computation of p' C^-1 p and the input stays stalled until it completes.
// The computation runs on one shared multiply-accumulate path, a
// one-bit-per-cycle divider and a two-bit-per-cycle square root. A pivot
// sum at or below zero ends the computation early with status 1 and a
// zero result.
// The result register lets loading of the next data set start while the
// previous result waits to be taken.
module cholesky_quadratic_form_unit #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row [3:0], col [7:4], value [39:8]
  input  logic [0:0]  s_axis_tuser,   // cmd [0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // quad_form [63:0]
  output logic [0:0]  m_axis_tuser,   // status [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);

  logic [cqf_pkg::DIM_W-1:0]        dim;
  logic                             idle;
  logic                             in_acc;
  cqf_pkg::ctrl_cmd_t               cmd;
  cqf_pkg::dp_status_t              status;
  logic [IW-1:0]                    ar, ac;
  logic signed [cqf_pkg::ACC_W-1:0] acc;
  logic                             out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim           <= 5'd16;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dim <= cfg_data;
      end
      if (cmd.load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= cmd.fail ? '0 : 64'(acc);
      m_axis_tuser <= cmd.fail;
    end
  end

  cqf_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (in_acc && s_axis_tlast),
    .dim      (dim),
    .status   (status),
    .out_free (out_free),
    .idle     (idle),
    .cmd      (cmd),
    .ar       (ar),
    .ac       (ac)
  );

  cqf_datapath #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_we    (in_acc),
    .in_cmd   (s_axis_tuser[0]),
    .in_row   (s_axis_tdata[3:0]),
    .in_col   (s_axis_tdata[7:4]),
    .in_value (s_axis_tdata[39:8]),
    .cmd      (cmd),
    .ar       (ar),
    .ac       (ac),
    .status   (status),
    .acc      (acc)
  );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for cholesky_quadratic_form_unit (p' C^-1 p).
// Depends on the RTL of the unit; drives stream and dimension ports and
// checks every result against a fixed-point Cholesky predictor or a directed value.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXD = 16;
  localparam int WATCH_LIMIT = 200000;
  localparam logic CMD_MAT = 1'b0;
  localparam logic CMD_VEC = 1'b1;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_NOT_PD = 1'b1;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic        cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] val;
    logic        last;
    bit          typed;
    logic [63:0] quad;
    logic        st;
  } entry_t;

  typedef struct {
    logic [63:0] quad;
    logic        st;
  } form_t;

  logic clk, rst;
  logic s_axis_tvalid = 1'b0, s_axis_tready, s_axis_tlast = 1'b0;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [4:0] cfg_data = '0;

  cholesky_quadratic_form_unit #(.MAX_DIM(MAXD)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  logic [31:0] mat [MAXD][MAXD];
  logic [31:0] vec [MAXD];
  bit mat_wr [MAXD][MAXD];
  bit vec_wr [MAXD];
  logic [4:0] dim_reg = 5'd16;
  form_t pending_forms [$];
  int errors = 0, items_sent = 0, forms_seen = 0, sets_sent = 0, not_pd_seen = 0;
  int s_idle = 0, r_idle = 0;
  bit hold_req = 0;
  int idle_run = 0;

  function automatic longint sadd(longint a, longint b);
    longint r;
    r = a + b;
    if (a > 0 && b > 0 && r < 0) return S64_MAX;
    if (a < 0 && b < 0 && r >= 0) return S64_MIN;
    return r;
  endfunction

  function automatic longint sdiv32(longint s, longint d);
    longint q;
    q = s / d;
    if (q > 64'sd2147483647) return 64'sd2147483647;
    if (q < -64'sd2147483648) return -64'sd2147483648;
    return q;
  endfunction

  function automatic longint root64(longint xin);
    logic [63:0] x, r, b;
    x = xin;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic form_t quad_form();
    form_t f;
    int n;
    longint s, rt;
    longint lo [MAXD][MAXD];
    longint piv [MAXD];
    longint sol [MAXD];
    n = dim_reg;
    if (n < 1) n = 1;
    if (n > MAXD) n = MAXD;
    f.quad = '0;
    f.st = ST_NOT_PD;
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        s = longint'($signed(mat[i][j])) * 65536;
        for (int k = 0; k < i; k++) s = sadd(s, -(lo[i][k] * lo[j][k]));
        if (i == j) begin
          if (s <= 0) return f;
          rt = root64(s);
          piv[i] = (rt > 64'sd2147483647) ? 64'sd2147483647 : rt;
          lo[i][i] = piv[i];
        end else begin
          lo[j][i] = sdiv32(s, piv[i]);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      s = longint'($signed(vec[i])) * 65536;
      for (int k = 0; k < i; k++) s = sadd(s, -(lo[i][k] * sol[k]));
      sol[i] = sdiv32(s, piv[i]);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = sol[i] * 65536;
      for (int k = i + 1; k < n; k++) s = sadd(s, -(lo[k][i] * sol[k]));
      sol[i] = sdiv32(s, piv[i]);
    end
    s = 0;
    for (int i = 0; i < n; i++) s = sadd(s, longint'($signed(vec[i])) * sol[i]);
    f.quad = s;
    f.st = ST_OK;
    return f;
  endfunction

  function automatic void absorb(entry_t e);
    form_t f;
    if (e.cmd == CMD_MAT) begin
      if (e.row <= e.col) begin
        mat[e.row][e.col] = e.val;
        mat_wr[e.row][e.col] = 1;
      end
    end else begin
      vec[e.row] = e.val;
      vec_wr[e.row] = 1;
    end
    if (e.last) begin
      f = quad_form();
      if (e.typed) begin
        f.quad = e.quad;
        f.st = e.st;
      end
      pending_forms.push_back(f);
    end
  endfunction

  task automatic send(entry_t e);
    while ($urandom_range(99) < s_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {e.val, e.col, e.row};
    s_axis_tuser <= e.cmd;
    s_axis_tlast <= e.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    absorb(e);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_forms.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_dim(logic [4:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dim_reg = d;
  endtask

  function automatic logic [31:0] pick(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  function automatic logic [31:0] entry_value(int mode, bit is_diag, int n, int lim);
    if (mode == 1) return $urandom;
    if (!is_diag) return pick(lim);
    case (mode)
      0: return n * lim + $urandom_range(lim, 1);
      2: return pick(lim);
      default: return 32'h7FFF_FFFF - $urandom_range(255);
    endcase
  endfunction

  task automatic send_set(int n);
    entry_t q [$];
    entry_t e, t;
    bit full;
    int mode, lim, p, j;
    full = $urandom_range(99) < 40;
    for (int r = 0; r < n; r++) begin
      if (!vec_wr[r]) full = 1;
      for (int c = r; c < n; c++) if (!mat_wr[r][c]) full = 1;
    end
    p = $urandom_range(99);
    mode = (p < 70) ? 0 : (p < 80) ? 1 : (p < 90) ? 2 : 3;
    lim = $urandom_range(1 << 24, 16);
    e.typed = 0;
    e.last = 0;
    e.quad = '0;
    e.st = ST_OK;
    if (full) begin
      for (int r = 0; r < n; r++) begin
        for (int c = r; c < n; c++) begin
          e.cmd = CMD_MAT; e.row = r; e.col = c;
          e.val = entry_value(mode, r == c, n, lim);
          q.push_back(e);
        end
        e.cmd = CMD_VEC; e.row = r; e.col = $urandom;
        e.val = (mode == 1) ? $urandom : pick(lim);
        q.push_back(e);
      end
    end else begin
      repeat ($urandom_range(3, 1)) begin
        e.cmd = $urandom_range(1); e.row = $urandom_range(n - 1);
        e.col = $urandom_range(n - 1, e.row);
        e.val = (e.cmd == CMD_VEC) ? pick(lim) : entry_value(mode, e.row == e.col, n, lim);
        q.push_back(e);
      end
    end
    repeat ($urandom_range(2)) begin
      e.cmd = $urandom_range(1); e.row = $urandom_range(15, 1);
      e.col = $urandom_range(e.row - 1);
      e.val = $urandom;
      if (e.cmd == CMD_VEC && e.row < n) e.row = 0;
      if (e.cmd == CMD_VEC && e.row == 0) e.cmd = CMD_MAT;
      q.push_back(e);
    end
    for (int i = q.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = q[i]; q[i] = q[j]; q[j] = t;
    end
    q[q.size() - 1].last = 1;
    foreach (q[i]) send(q[i]);
    sets_sent++;
  endtask

  always @(posedge clk) begin
    form_t f;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      forms_seen++;
      if (m_axis_tuser[0] == ST_NOT_PD) not_pd_seen++;
      if (pending_forms.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: quad %h status %0d",
                                   m_axis_tdata, m_axis_tuser[0]);
      end else begin
        f = pending_forms.pop_front();
        if (f.quad !== m_axis_tdata || f.st !== m_axis_tuser[0]) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected quad %h status %0d, got quad %h status %0d",
                     f.quad, f.st, m_axis_tdata, m_axis_tuser[0]);
        end
      end
    end
    if (hold_req) begin
      hold_req = 0;
      m_axis_tready <= 1'b0;
      repeat (4000) @(posedge clk);
    end else begin
      m_axis_tready <= ($urandom_range(99) >= r_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCH_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  entry_t directed [13];
  logic [4:0] dim_plan [16] = '{0, 3, 1, 4, 2, 31, 5, 3, 17, 6, 2, 16, 4, 8, 1, 3};

  initial begin
    int n, budget;
    directed = '{
      '{CMD_MAT, 0, 0, 32'h0001_0000, 0, 0, '0, ST_OK},
      '{CMD_VEC, 0, 0, 32'h0001_0000, 1, 1, 64'h1_0000_0000, ST_OK},
      '{CMD_MAT, 0, 0, 32'h0000_0000, 1, 1, '0, ST_NOT_PD},
      '{CMD_MAT, 0, 0, 32'hFFFF_0000, 1, 1, '0, ST_NOT_PD},
      '{CMD_MAT, 0, 0, 32'h0001_0000, 0, 0, '0, ST_OK},
      '{CMD_VEC, 0, 0, 32'h8000_0000, 1, 1, 64'h4000_0000_0000_0000, ST_OK},
      '{CMD_VEC, 0, 15, 32'h7FFF_FFFF, 1, 0, '0, ST_OK},
      '{CMD_MAT, 1, 0, 32'h0000_0000, 1, 0, '0, ST_OK},
      '{CMD_MAT, 0, 0, 32'h7FFF_FFFF, 1, 0, '0, ST_OK},
      '{CMD_MAT, 0, 0, 32'h0000_0001, 1, 0, '0, ST_OK},
      '{CMD_MAT, 15, 15, 32'h8000_0000, 0, 0, '0, ST_OK},
      '{CMD_VEC, 15, 0, 32'hFFFF_FFFF, 0, 0, '0, ST_OK},
      '{CMD_MAT, 0, 15, 32'h5555_AAAA, 1, 0, '0, ST_OK}
    };
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_dim(5'd1);
    foreach (directed[i]) send(directed[i]);
    for (int m = 0; m < 3; m++) begin
      s_idle = (m == 0) ? 34 : (m == 1) ? 85 : 0;
      r_idle = (m == 0) ? 85 : (m == 1) ? 34 : 0;
      foreach (dim_plan[d]) begin
        set_dim(dim_plan[d]);
        n = (dim_plan[d] == 0) ? 1 : (dim_plan[d] > MAXD) ? MAXD : dim_plan[d];
        budget = items_sent + 28;
        if (n >= 8) send_set(n);
        else while (items_sent < budget) send_set(n);
      end
    end
    set_dim(5'd2);
    hold_req = 1;
    repeat (6) send_set(2);
    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d input and %0d result transactions in %0d data sets,",
             items_sent, forms_seen, sets_sent);
    $display("%0d not positive definite; dimensions 0 to 31, three idle patterns, long stall.",
             not_pd_seen);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/cqf_pkg.sv
rtl/core/cqf_sqrt.sv
rtl/core/cqf_div.sv
rtl/core/cqf_datapath.sv
rtl/core/cqf_ctrl.sv
rtl/core/cholesky_quadratic_form_unit.sv
bench/testbench.sv
